>>> hw/rtl/fmli_pkg.sv
// fmli_pkg: shared types and constants of the field map linear interpolator
// no dependencies; used by fmli_div and field_map_linear_interpolator
`default_nettype none

package fmli_pkg;

   localparam int unsigned DATA_W    = 32;
   localparam int unsigned CSR_IDX_W = 4;

   // request command codes
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAGNET_CENTER = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_SCALE   = 4'd1;

   localparam logic signed [DATA_W-1:0] FIELD_SCALE_RESET = 32'sd65536;

   // interpolation fraction and output scaling shift
   localparam int unsigned FRAC_BITS  = 29;
   localparam int unsigned SCALE_BITS = 16;
   localparam int unsigned QUOT_W     = FRAC_BITS + 1;
   localparam int unsigned STEP_W     = $clog2(FRAC_BITS + 1);

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/fmli_table_mem.sv
// fmli_table_mem: breakpoint position and value memories, one write and one read port
// registered read data; no package dependency
`default_nettype none

module fmli_table_mem #(
   parameter int unsigned DEPTH = 128,
   parameter int unsigned AW    = 7
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [31:0]   wr_pos,
   input  wire logic [31:0]   wr_val,
   input  wire logic [AW-1:0] rd_addr,
   output logic [31:0]        rd_pos,
   output logic [31:0]        rd_val
);

   logic [31:0] pos_mem [DEPTH];
   logic [31:0] val_mem [DEPTH];
   logic [31:0] rd_pos_ff;
   logic [31:0] rd_val_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem[wr_addr] <= wr_pos;
         val_mem[wr_addr] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff <= pos_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

   assign rd_pos = rd_pos_ff;
   assign rd_val = rd_val_ff;

endmodule

`default_nettype wire

>>> hw/rtl/fmli_div.sv
// fmli_div: restoring divider for the segment fraction, floor(d * 2^29 / w) with d <= w
// one quotient bit per cycle; depends on fmli_pkg
`default_nettype none

module fmli_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fmli_pkg::div_req_type req,
   output fmli_pkg::div_rsp_type      rsp
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [fmli_pkg::STEP_W-1:0]       cnt_ff, cnt_in;
   logic [fmli_pkg::DATA_W-1:0]       rem_ff, rem_in;
   logic [fmli_pkg::DATA_W-1:0]       dvs_ff, dvs_in;
   logic [fmli_pkg::QUOT_W-1:0]       quo_ff, quo_in;
   logic [fmli_pkg::DATA_W:0]         shifted;
   logic [fmli_pkg::DATA_W:0]         diff;
   logic                              start_ge;
   logic                              step_ge;

   assign shifted  = {rem_ff, 1'b0};
   assign diff     = shifted - {1'b0, dvs_ff};
   assign step_ge  = shifted >= {1'b0, dvs_ff};
   assign start_ge = req.dividend >= req.divisor;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = fmli_pkg::STEP_W'(fmli_pkg::FRAC_BITS);
         dvs_in  = req.divisor;
         rem_in  = start_ge ? (req.dividend - req.divisor) : req.dividend;
         quo_in  = fmli_pkg::QUOT_W'(start_ge);
      end else if (busy_ff) begin
         rem_in = step_ge ? diff[fmli_pkg::DATA_W-1:0] : shifted[fmli_pkg::DATA_W-1:0];
         quo_in = {quo_ff[fmli_pkg::QUOT_W-2:0], step_ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == fmli_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/field_map_linear_interpolator.sv
// field_map_linear_interpolator: piecewise linear field map with loadable breakpoint table
// depends on fmli_pkg, fmli_table_mem and fmli_div
//
// usage
//   requests enter on req_* (valid/stall); each request gives exactly one response
//   on rsp_* (valid/stall). commands: clear, append breakpoint, query field.
//   csr_* writes magnet_center (index 0) and field_scale (index 1); csr_ready is
//   high while the block is idle.
//   clear and append pass from acceptance to response through decode, result
//   and output register.
//   a query in range runs a binary search, one memory read and compare per
//   step, fetches the segment ends, sets up and runs the bit serial division,
//   then multiplies, rounds, adds and scales, and saturates; a query out of
//   range or with under two points goes straight from decode to result.
//   one request is in flight at a time; req_stall is high from acceptance until
//   the response enters the output register.
//   reset empties the table and loads magnet_center 0 and field_scale 1.0.
//   the next request is accepted while a response waits in the output register;
//   a finished response waits inside, req_stall high, while rsp_stall holds the last
`default_nettype none

module field_map_linear_interpolator #(
   parameter int unsigned TABLE_DEPTH = 128
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_command,
   input  wire logic signed [31:0]                 req_position_z,
   input  wire logic signed [31:0]                 req_point_z,
   input  wire logic signed [31:0]                 req_point_b,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [31:0]                      rsp_field_y,
   output logic                                    rsp_in_range,
   output logic                                    rsp_load_rejected,
   output logic [7:0]                              rsp_points_held,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [fmli_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [31:0]                        csr_data
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EXEC   = 4'd1;
   localparam logic [3:0] ST_SEARCH = 4'd2;
   localparam logic [3:0] ST_CMP    = 4'd3;
   localparam logic [3:0] ST_RD_LO  = 4'd4;
   localparam logic [3:0] ST_RD_HI  = 4'd5;
   localparam logic [3:0] ST_SETUP  = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_MUL    = 4'd8;
   localparam logic [3:0] ST_ABS    = 4'd9;
   localparam logic [3:0] ST_RND    = 4'd10;
   localparam logic [3:0] ST_ADD    = 4'd11;
   localparam logic [3:0] ST_SAT    = 4'd12;
   localparam logic [3:0] ST_DONE   = 4'd13;

   localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
   localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

   logic [3:0]             state_ff, state_in;
   logic [1:0]             cmd_ff, cmd_in;
   logic signed [32:0]     z_ff, z_in;
   logic [31:0]            pz_ff, pz_in;
   logic [31:0]            pb_ff, pb_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic signed [31:0]     span_lo_ff, span_lo_in;
   logic signed [31:0]     span_hi_ff, span_hi_in;
   logic signed [31:0]     center_ff, center_in;
   logic signed [31:0]     scale_ff, scale_in;
   logic [AW-1:0]          lo_ff, lo_in;
   logic [AW-1:0]          hi_ff, hi_in;
   logic [AW-1:0]          mid_ff, mid_in;
   logic signed [31:0]     z1_ff, z1_in;
   logic signed [31:0]     b1_ff, b1_in;
   logic signed [31:0]     z2_ff, z2_in;
   logic signed [31:0]     b2_ff, b2_in;
   logic signed [32:0]     diff_ff, diff_in;
   logic [fmli_pkg::QUOT_W-1:0] t_ff, t_in;
   logic                   phase_ff, phase_in;
   logic signed [63:0]     prod_ff, prod_in;
   logic [63:0]            mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic signed [49:0]     rq_ff, rq_in;
   logic signed [31:0]     rel_ff, rel_in;
   logic signed [31:0]     res_field_ff, res_field_in;
   logic                   res_range_ff, res_range_in;
   logic                   res_rej_ff, res_rej_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]     rsp_field_ff, rsp_field_in;
   logic                   rsp_range_ff, rsp_range_in;
   logic                   rsp_rej_ff, rsp_rej_in;
   logic [7:0]             rsp_held_ff, rsp_held_in;

   logic                   req_take;
   logic                   rsp_load;
   logic                   mem_wr_en;
   logic [AW-1:0]          mem_rd_addr;
   logic [31:0]            mem_rd_pos;
   logic [31:0]            mem_rd_val;
   logic [AW:0]            mid_sum;
   logic signed [33:0]     seg_d;
   logic signed [33:0]     seg_w;
   logic [31:0]            seg_d_clamped;
   logic signed [32:0]     mul_a;
   logic signed [32:0]     mul_b;
   logic signed [65:0]     mul_p;
   logic [64:0]            rnd_sum;
   logic [48:0]            rnd_q;
   logic                   q_in_span;
   fmli_pkg::div_req_type  div_req;
   fmli_pkg::div_rsp_type  div_rsp;

   fmli_table_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (cnt_ff[AW-1:0]),
      .wr_pos  (pz_ff),
      .wr_val  (pb_ff),
      .rd_addr (mem_rd_addr),
      .rd_pos  (mem_rd_pos),
      .rd_val  (mem_rd_val)
   );

   fmli_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   assign mem_wr_en = (state_ff == ST_EXEC) && (cmd_ff == fmli_pkg::CMD_APPEND)
                      && (cnt_ff < CW'(TABLE_DEPTH));

   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} + {{AW{1'b0}}, 1'b1};

   always_comb begin
      unique case (state_ff)
         ST_SEARCH: mem_rd_addr = (lo_ff == hi_ff) ? lo_ff : mid_sum[AW:1];
         ST_RD_LO:  mem_rd_addr = lo_ff + 1'b1;
         default:   mem_rd_addr = lo_ff;
      endcase
   end

   // segment offset and width, offset clamped into the segment
   assign seg_d = {z_ff[32], z_ff} - {{2{z1_ff[31]}}, z1_ff};
   assign seg_w = {{2{z2_ff[31]}}, z2_ff} - {{2{z1_ff[31]}}, z1_ff};
   always_comb begin
      if (seg_d < 0) begin
         seg_d_clamped = '0;
      end else if (seg_d > seg_w) begin
         seg_d_clamped = seg_w[31:0];
      end else begin
         seg_d_clamped = seg_d[31:0];
      end
   end

   assign div_req.start    = (state_ff == ST_SETUP) && (z2_ff > z1_ff);
   assign div_req.dividend = seg_d_clamped;
   assign div_req.divisor  = seg_w[31:0];

   // shared multiplier: slope times fraction, then relative field times scale
   assign mul_a = phase_ff ? {rel_ff[31], rel_ff} : diff_ff;
   assign mul_b = phase_ff ? {scale_ff[31], scale_ff}
                           : $signed({{(33 - fmli_pkg::QUOT_W){1'b0}}, t_ff});
   assign mul_p = mul_a * mul_b;

   assign rnd_sum = phase_ff ? ({1'b0, mag_ff} + (65'd1 << (fmli_pkg::SCALE_BITS - 1)))
                             : ({1'b0, mag_ff} + (65'd1 << (fmli_pkg::FRAC_BITS - 1)));
   assign rnd_q   = phase_ff ? rnd_sum[fmli_pkg::SCALE_BITS +: 49]
                             : {13'd0, rnd_sum[64:fmli_pkg::FRAC_BITS]};

   assign q_in_span = (cnt_ff >= CW'(2))
                      && (z_ff >= $signed({span_lo_ff[31], span_lo_ff}))
                      && (z_ff <= $signed({span_hi_ff[31], span_hi_ff}));

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      z_in         = z_ff;
      pz_in        = pz_ff;
      pb_in        = pb_ff;
      cnt_in       = cnt_ff;
      span_lo_in   = span_lo_ff;
      span_hi_in   = span_hi_ff;
      center_in    = center_ff;
      scale_in     = scale_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      z1_in        = z1_ff;
      b1_in        = b1_ff;
      z2_in        = z2_ff;
      b2_in        = b2_ff;
      diff_in      = diff_ff;
      t_in         = t_ff;
      phase_in     = phase_ff;
      prod_in      = prod_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rq_in        = rq_ff;
      rel_in       = rel_ff;
      res_field_in = res_field_ff;
      res_range_in = res_range_ff;
      res_rej_in   = res_rej_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == fmli_pkg::CSR_MAGNET_CENTER) begin
            center_in = csr_data;
         end else if (csr_index == fmli_pkg::CSR_FIELD_SCALE) begin
            scale_in = csr_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cmd_in   = req_command;
               z_in     = {req_position_z[31], req_position_z} - {center_ff[31], center_ff};
               pz_in    = req_point_z;
               pb_in    = req_point_b;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_field_in = '0;
            res_range_in = 1'b0;
            res_rej_in   = 1'b0;
            state_in     = ST_DONE;
            unique case (cmd_ff)
               fmli_pkg::CMD_CLEAR: begin
                  cnt_in     = '0;
                  span_lo_in = '0;
                  span_hi_in = '0;
               end
               fmli_pkg::CMD_APPEND: begin
                  if (cnt_ff >= CW'(TABLE_DEPTH)) begin
                     res_rej_in = 1'b1;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                     if (cnt_ff == '0) begin
                        span_lo_in = pz_ff;
                        span_hi_in = pz_ff;
                     end else begin
                        if ($signed(pz_ff) < span_lo_ff) span_lo_in = pz_ff;
                        if ($signed(pz_ff) > span_hi_ff) span_hi_in = pz_ff;
                     end
                  end
               end
               fmli_pkg::CMD_QUERY: begin
                  if (q_in_span) begin
                     lo_in    = '0;
                     hi_in    = AW'(cnt_ff - CW'(2));
                     state_in = ST_SEARCH;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SEARCH: begin
            mid_in   = mid_sum[AW:1];
            state_in = (lo_ff == hi_ff) ? ST_RD_LO : ST_CMP;
         end
         ST_CMP: begin
            if ($signed({mem_rd_pos[31], mem_rd_pos}) <= z_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - 1'b1;
            end
            state_in = ST_SEARCH;
         end
         ST_RD_LO: begin
            z1_in    = mem_rd_pos;
            b1_in    = mem_rd_val;
            state_in = ST_RD_HI;
         end
         ST_RD_HI: begin
            z2_in    = mem_rd_pos;
            b2_in    = mem_rd_val;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            diff_in = {b2_ff[31], b2_ff} - {b1_ff[31], b1_ff};
            if (z2_ff > z1_ff) begin
               phase_in = 1'b0;
               state_in = ST_DIV;
            end else begin
               rel_in   = b1_ff;
               phase_in = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               t_in     = div_rsp.quotient;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mul_p[63:0];
            state_in = ST_ABS;
         end
         ST_ABS: begin
            neg_in   = prod_ff[63];
            mag_in   = prod_ff[63] ? 64'(-prod_ff) : prod_ff;
            state_in = ST_RND;
         end
         ST_RND: begin
            rq_in    = neg_ff ? -$signed({1'b0, rnd_q}) : $signed({1'b0, rnd_q});
            state_in = phase_ff ? ST_SAT : ST_ADD;
         end
         ST_ADD: begin
            rel_in   = b1_ff + rq_ff[31:0];
            phase_in = 1'b1;
            state_in = ST_MUL;
         end
         ST_SAT: begin
            if (rq_ff > SAT_MAX) begin
               res_field_in = SAT_MAX[31:0];
            end else if (rq_ff < SAT_MIN) begin
               res_field_in = SAT_MIN[31:0];
            end else begin
               res_field_in = rq_ff[31:0];
            end
            res_range_in = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_field_in = rsp_field_ff;
      rsp_range_in = rsp_range_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_held_in  = rsp_held_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_field_in = res_field_ff;
         rsp_range_in = res_range_ff;
         rsp_rej_in   = res_rej_ff;
         rsp_held_in  = 8'(cnt_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         span_lo_ff   <= '0;
         span_hi_ff   <= '0;
         center_ff    <= '0;
         scale_ff     <= fmli_pkg::FIELD_SCALE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         span_lo_ff   <= span_lo_in;
         span_hi_ff   <= span_hi_in;
         center_ff    <= center_in;
         scale_ff     <= scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      z_ff         <= z_in;
      pz_ff        <= pz_in;
      pb_ff        <= pb_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      z1_ff        <= z1_in;
      b1_ff        <= b1_in;
      z2_ff        <= z2_in;
      b2_ff        <= b2_in;
      diff_ff      <= diff_in;
      t_ff         <= t_in;
      phase_ff     <= phase_in;
      prod_ff      <= prod_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      rq_ff        <= rq_in;
      rel_ff       <= rel_in;
      res_field_ff <= res_field_in;
      res_range_ff <= res_range_in;
      res_rej_ff   <= res_rej_in;
      rsp_field_ff <= rsp_field_in;
      rsp_range_ff <= rsp_range_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_held_ff  <= rsp_held_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_field_y       = rsp_field_ff;
   assign rsp_in_range      = rsp_range_ff;
   assign rsp_load_rejected = rsp_rej_ff;
   assign rsp_points_held   = rsp_held_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(TABLE_DEPTH))
      else $error("point count above table depth");

   a_search_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH || state_ff == ST_CMP) |-> (lo_ff <= hi_ff))
      else $error("search bounds crossed");

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_range) |-> (rsp_field_y == '0))
      else $error("nonzero field without in_range");

   a_reject_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_load_rejected)
         |-> (!rsp_in_range && rsp_points_held == 8'(TABLE_DEPTH)))
      else $error("rejection while table not full");

   a_div_in_div: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside division state");

endmodule

`default_nettype wire
